FILE: src/jsu_pkg.sv
package jsu_pkg;

    // Widths of the item fields.
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int ERR_W   = 3;
    localparam int MODE_W  = 3;
    localparam int SEEN_W  = 2;
    localparam int CP_W    = 16;
    localparam int NIB_W   = 4;

    // Most results that one input item can cause.
    localparam int RES_MAX = 3;
    localparam int CNT_W   = 2;
    localparam int IDX_W   = 2;

    // Index of the last of the four hex digits in a unicode escape.
    localparam logic [SEEN_W-1:0] HEX_LAST_DIGIT = SEEN_W'(4 - 1);

    // Parse modes. Codes four to seven behave as waiting.
    localparam logic [MODE_W-1:0] MODE_WAIT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ESC  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HEX  = 3'd3;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NO_QUOTE = 3'd0;
    localparam logic [ERR_W-1:0] ERR_CTRL     = 3'd1;
    localparam logic [ERR_W-1:0] ERR_ESC_CUT  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_UNI_CUT  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BAD_HEX  = 3'd4;
    localparam logic [ERR_W-1:0] ERR_BAD_ESC  = 3'd5;
    localparam logic [ERR_W-1:0] ERR_UNTERM   = 3'd6;

    // Characters of interest.
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
    localparam logic [BYTE_W-1:0] CH_F      = 8'h66;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
    localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
    localparam logic [BYTE_W-1:0] CH_U      = 8'h75;
    localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;

    localparam logic [BYTE_W-1:0] CODE_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] CODE_FF  = 8'h0C;
    localparam logic [BYTE_W-1:0] CODE_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CODE_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CODE_TAB = 8'h09;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              text_end;
    } jsu_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [KIND_W-1:0] kind;
        logic [ERR_W-1:0]  error_code;
        logic              last;
    } jsu_res_t;

    typedef struct packed {
        logic [MODE_W-1:0] parse_mode;
        logic [SEEN_W-1:0] hex_digits_seen;
        logic [CP_W-1:0]   code_point_acc;
        logic              bad_hex_seen;
    } jsu_state_t;

    // All results of one input item, slot 0 first.
    typedef struct packed {
        jsu_res_t [RES_MAX-1:0] res;
        logic [CNT_W-1:0]       cnt;
    } jsu_batch_t;

    typedef struct packed {
        logic             ok;
        logic [NIB_W-1:0] nib;
    } jsu_hex_t;

    localparam jsu_state_t STATE_IDLE = '{
        parse_mode: MODE_WAIT, hex_digits_seen: '0, code_point_acc: '0, bad_hex_seen: 1'b0};

    function automatic jsu_hex_t hex_decode(input logic [BYTE_W-1:0] c);
        jsu_hex_t h;
        h.ok  = 1'b1;
        h.nib = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.nib = c[NIB_W-1:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            // Letters a to f and A to F share their low three bits.
            h.nib = NIB_W'(c[2:0]) + NIB_W'(9);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic jsu_res_t mk_res(input logic [KIND_W-1:0] kind,
                                        input logic [ERR_W-1:0]  code,
                                        input logic [BYTE_W-1:0] b);
        jsu_res_t r;
        r.out_byte   = b;
        r.kind       = kind;
        r.error_code = code;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

FILE: src/jsu_decode.sv
module jsu_decode
    import jsu_pkg::*;
(
    input  jsu_state_t state,
    input  jsu_in_t    item,
    output jsu_state_t state_next,
    output jsu_batch_t batch
);

    jsu_hex_t          hv;
    logic [CP_W-1:0]   cp;
    logic              bad;
    logic [BYTE_W-1:0] c;

    assign c  = item.text_byte;
    assign hv = hex_decode(c);
    assign cp = {state.code_point_acc[CP_W-NIB_W-1:0], hv.nib};
    assign bad = state.bad_hex_seen | ~hv.ok;

    always_comb begin
        state_next = state;
        batch      = '0;

        unique case (state.parse_mode)
            MODE_STR: begin
                if (item.text_end) begin
                    state_next   = STATE_IDLE;
                    batch.res[0] = mk_res(KIND_ERR, ERR_UNTERM, '0);
                    batch.cnt    = CNT_W'(1);
                end else if (c == CH_QUOTE) begin
                    state_next   = STATE_IDLE;
                    batch.res[0] = mk_res(KIND_DONE, ERR_NONE, '0);
                    batch.cnt    = CNT_W'(1);
                end else if (c < CTRL_LIMIT) begin
                    state_next   = STATE_IDLE;
                    batch.res[0] = mk_res(KIND_ERR, ERR_CTRL, '0);
                    batch.cnt    = CNT_W'(1);
                end else if (c == CH_BSLASH) begin
                    state_next.parse_mode = MODE_ESC;
                end else begin
                    batch.res[0] = mk_res(KIND_DATA, ERR_NONE, c);
                    batch.cnt    = CNT_W'(1);
                end
            end
            MODE_ESC: begin
                if (item.text_end) begin
                    state_next   = STATE_IDLE;
                    batch.res[0] = mk_res(KIND_ERR, ERR_ESC_CUT, '0);
                    batch.cnt    = CNT_W'(1);
                end else begin
                    state_next.parse_mode = MODE_STR;
                    batch.cnt             = CNT_W'(1);
                    priority case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH:
                              batch.res[0] = mk_res(KIND_DATA, ERR_NONE, c);
                        CH_B: batch.res[0] = mk_res(KIND_DATA, ERR_NONE, CODE_BS);
                        CH_F: batch.res[0] = mk_res(KIND_DATA, ERR_NONE, CODE_FF);
                        CH_N: batch.res[0] = mk_res(KIND_DATA, ERR_NONE, CODE_LF);
                        CH_R: batch.res[0] = mk_res(KIND_DATA, ERR_NONE, CODE_CR);
                        CH_T: batch.res[0] = mk_res(KIND_DATA, ERR_NONE, CODE_TAB);
                        CH_U: begin
                            state_next = '{parse_mode: MODE_HEX, hex_digits_seen: '0,
                                           code_point_acc: '0, bad_hex_seen: 1'b0};
                            batch.cnt  = '0;
                        end
                        default: begin
                            state_next   = STATE_IDLE;
                            batch.res[0] = mk_res(KIND_ERR, ERR_BAD_ESC, '0);
                        end
                    endcase
                end
            end
            MODE_HEX: begin
                if (item.text_end) begin
                    state_next   = STATE_IDLE;
                    batch.res[0] = mk_res(KIND_ERR, ERR_UNI_CUT, '0);
                    batch.cnt    = CNT_W'(1);
                end else if (state.hex_digits_seen == HEX_LAST_DIGIT) begin
                    if (bad) begin
                        state_next   = STATE_IDLE;
                        batch.res[0] = mk_res(KIND_ERR, ERR_BAD_HEX, '0);
                        batch.cnt    = CNT_W'(1);
                    end else begin
                        state_next            = STATE_IDLE;
                        state_next.parse_mode = MODE_STR;
                        // UTF-8 form of the gathered code point.
                        if (cp < 16'h0080) begin
                            batch.res[0] = mk_res(KIND_DATA, ERR_NONE, cp[BYTE_W-1:0]);
                            batch.cnt    = CNT_W'(1);
                        end else if (cp < 16'h0800) begin
                            batch.res[0] = mk_res(KIND_DATA, ERR_NONE, {3'b110, cp[10:6]});
                            batch.res[1] = mk_res(KIND_DATA, ERR_NONE, {2'b10, cp[5:0]});
                            batch.cnt    = CNT_W'(2);
                        end else begin
                            batch.res[0] = mk_res(KIND_DATA, ERR_NONE, {4'b1110, cp[15:12]});
                            batch.res[1] = mk_res(KIND_DATA, ERR_NONE, {2'b10, cp[11:6]});
                            batch.res[2] = mk_res(KIND_DATA, ERR_NONE, {2'b10, cp[5:0]});
                            batch.cnt    = CNT_W'(3);
                        end
                    end
                end else begin
                    state_next.code_point_acc  = cp;
                    state_next.hex_digits_seen = state.hex_digits_seen + SEEN_W'(1);
                    state_next.bad_hex_seen    = bad;
                end
            end
            default: begin
                if (!item.text_end && c == CH_QUOTE) begin
                    state_next            = STATE_IDLE;
                    state_next.parse_mode = MODE_STR;
                end else begin
                    state_next   = STATE_IDLE;
                    batch.res[0] = mk_res(KIND_ERR, ERR_NO_QUOTE, '0);
                    batch.cnt    = CNT_W'(1);
                end
            end
        endcase

        // Flag the final result of the item.
        for (int i = 0; i < RES_MAX; i++) begin
            batch.res[i].last = (batch.cnt == CNT_W'(i + 1));
        end
    end

endmodule

FILE: src/jsu_resbuf.sv
module jsu_resbuf
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  jsu_batch_t batch,
    output logic       free,
    output logic       m_valid,
    input  logic       m_ready,
    output jsu_res_t   m_data
);

    jsu_batch_t       batch_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             valid_reg;
    logic             at_last;

    assign at_last = (CNT_W'(idx_reg) + CNT_W'(1)) == batch_reg.cnt;
    assign free    = !valid_reg || (m_ready && at_last);
    assign m_valid = valid_reg;

    always_comb begin
        unique case (idx_reg)
            2'd0:    m_data = batch_reg.res[0];
            2'd1:    m_data = batch_reg.res[1];
            2'd2:    m_data = batch_reg.res[2];
            default: m_data = batch_reg.res[0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= (batch.cnt != '0);
            idx_reg   <= '0;
        end else if (valid_reg && m_ready) begin
            if (at_last) begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            batch_reg <= batch;
        end
    end

endmodule

FILE: src/json_string_unescaper_unit.sv
// JSON string unescaper. Feed the text of one JSON string, opening quote
// first, one byte per item; text_end marks the end of the text and carries no
// byte. Each item yields zero to three results: decoded bytes (kind 0), a
// completion on the closing quote (kind 1), or an error (kind 2) with its code,
// and the final result of an item has last set. A \u escape emits the UTF-8
// form of its 16-bit code point; surrogates are not paired. After a completion
// or an error the block waits for a new opening quote. Items are taken at one
// per cycle as long as each produces at most one result and the result port
// is not stalled; an item that yields several results holds the single result
// port until its last result is taken, so that port sets the rate. An accepted
// item waits in the input register, then its results go to the result buffer.
module json_string_unescaper_unit
    import jsu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  jsu_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output jsu_res_t m_data
);

    jsu_in_t    in_reg;
    logic       in_valid_reg;
    jsu_state_t state_reg;
    jsu_state_t state_next;
    jsu_batch_t batch;
    logic       buf_free;
    logic       load;

    // The held item is decoded and its results loaded once the result
    // buffer is empty or hands over its final result in this cycle.
    assign load    = in_valid_reg && buf_free;
    assign s_ready = !in_valid_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= STATE_IDLE;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (load) begin
                in_valid_reg <= 1'b0;
            end
            if (load) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    jsu_decode u_decode (
        .state      (state_reg),
        .item       (in_reg),
        .state_next (state_next),
        .batch      (batch)
    );

    jsu_resbuf u_resbuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .batch   (batch),
        .free    (buf_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: src/jsu_checker.sv
module jsu_checker
    import jsu_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input jsu_res_t m_data
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // With nothing waiting at either side, the block takes a new item.
    a_in_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_valid && !m_valid |=> s_ready)
        else $error("input blocked while the block is empty");

    // Completion and error close the results of their item and carry no byte.
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind != KIND_DATA |-> m_data.last && m_data.out_byte == '0)
        else $error("completion or error not final or carries a byte");

    // Data bytes and completions carry no error code.
    a_data_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind != KIND_ERR |-> m_data.error_code == ERR_NONE)
        else $error("error code on a non-error result");

endmodule

bind json_string_unescaper_unit jsu_checker u_jsu_checker (.*);
